// ===== rtl/nearest_value_binary_search_defines.svh =====
// assertion macros used by the checker file of the nearest value search block
// no dependencies; expects clk, and rst_n for NVBS_ASSERT, in the scope of each use
`ifndef NEAREST_VALUE_BINARY_SEARCH_DEFINES_SVH
`define NEAREST_VALUE_BINARY_SEARCH_DEFINES_SVH

// checked only outside reset
`define NVBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define NVBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/nvbs_pkg.sv =====
// package for the nearest value search block: default sizes and opcodes
// no dependencies
package nvbs_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// ===== rtl/nearest_value_binary_search.sv =====
// top level of the nearest value search block: table memory and search sequencer
// depends on nvbs_pkg
//
// Holds a table of TABLE_DEPTH signed values, each with a missing flag that orders as minus
// infinity. A load word (op 0) writes one entry; indexes at or above TABLE_DEPTH are
// dropped. A query word (op 1) runs a lower-bound binary search over the first entries
// counted by cfg_wr_data (held in cfg_count_r, saturated to TABLE_DEPTH) and returns one
// word with the index of the nearer neighbour: ties go to the lower one, a missing
// neighbour gives the upper one, an empty table gives 0. The table sits in one memory with
// a single registered read port, and every search step is one read of it; a full output
// register that stays stalled holds the result back. One word is in work at a time;
// in_stall is high until the result has entered the output register. Table entries are
// undefined until loaded.
module nearest_value_binary_search
  import nvbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_wr_en,
  input  logic [CW-1:0]                 cfg_wr_data,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [IW-1:0]                 in_entry_index,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          in_missing,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [IW-1:0]                 out_nearest_index
);

  localparam int VW = VALUE_WIDTH;

  typedef struct packed {
    logic                 miss;
    logic signed [VW-1:0] val;
  } slot_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PROBE = 5'b00010,
    ST_LEFT  = 5'b00100,
    ST_RIGHT = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  function automatic logic [VW-1:0] abs_diff(input logic signed [VW-1:0] a,
                                             input logic signed [VW-1:0] b);
    logic [VW:0] d;
    logic [VW:0] m;
    begin
      d = {a[VW-1], a} - {b[VW-1], b};
      m = -d;
      return d[VW] ? m[VW-1:0] : d[VW-1:0];
    end
  endfunction

  slot_t                table_mem [TABLE_DEPTH];
  slot_t                rd_data_r;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic                 wr_en;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cfg_count_r;
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [CW-1:0]        mid_r, mid_nxt;
  logic signed [VW-1:0] target_r, target_nxt;
  logic                 left_miss_r, left_miss_nxt;
  logic [VW-1:0]        left_dist_r, left_dist_nxt;
  logic [IW-1:0]        res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IW-1:0]        out_index_r, out_index_nxt;

  logic [CW-1:0]        sat_count;
  logic [CW-1:0]        sat_half;
  logic                 go_right;
  logic [CW-1:0]        srch_lo;
  logic [CW-1:0]        srch_hi;
  logic [CW-1:0]        srch_mid;
  logic [CW-1:0]        srch_lo_m1;
  logic [CW-1:0]        lo_m1;
  logic [CW-1:0]        n_m1;

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_index_r;

  assign wr_en = in_valid && !in_stall && (in_op == OP_LOAD) &&
                 ((IW + 1)'(in_entry_index) < (IW + 1)'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[in_entry_index] <= '{miss: in_missing, val: in_value};
    end
    if (rd_en) begin
      rd_data_r <= table_mem[rd_addr];
    end
  end

  assign sat_count  = (cfg_count_r > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cfg_count_r;
  assign sat_half   = sat_count >> 1;
  assign go_right   = rd_data_r.miss || (rd_data_r.val < target_r);
  assign srch_lo    = go_right ? mid_r + 1'b1 : lo_r;
  assign srch_hi    = go_right ? hi_r : mid_r;
  assign srch_mid   = srch_lo + ((srch_hi - srch_lo) >> 1);
  assign srch_lo_m1 = srch_lo - 1'b1;
  assign lo_m1      = lo_r - 1'b1;
  assign n_m1       = n_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    target_nxt    = target_r;
    left_miss_nxt = left_miss_r;
    left_dist_nxt = left_dist_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_index_nxt = out_index_r;
    rd_en         = 1'b0;
    rd_addr       = mid_r[IW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_op == OP_QUERY)) begin
          target_nxt = in_value;
          n_nxt      = sat_count;
          lo_nxt     = '0;
          hi_nxt     = sat_count;
          if (sat_count == '0) begin
            res_nxt   = '0;
            state_nxt = ST_EMIT;
          end else begin
            mid_nxt   = sat_half;
            rd_en     = 1'b1;
            rd_addr   = sat_half[IW-1:0];
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        lo_nxt = srch_lo;
        hi_nxt = srch_hi;
        if (srch_lo < srch_hi) begin
          mid_nxt = srch_mid;
          rd_en   = 1'b1;
          rd_addr = srch_mid[IW-1:0];
        end else if (srch_lo == '0) begin
          res_nxt   = '0;
          state_nxt = ST_EMIT;
        end else if (srch_lo == n_r) begin
          res_nxt   = n_m1[IW-1:0];
          state_nxt = ST_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = srch_lo_m1[IW-1:0];
          state_nxt = ST_LEFT;
        end
      end
      ST_LEFT: begin
        left_miss_nxt = rd_data_r.miss;
        left_dist_nxt = abs_diff(rd_data_r.val, target_r);
        rd_en         = 1'b1;
        rd_addr       = lo_r[IW-1:0];
        state_nxt     = ST_RIGHT;
      end
      ST_RIGHT: begin
        if (left_miss_r || rd_data_r.miss) begin
          res_nxt = lo_r[IW-1:0];
        end else if (left_dist_r <= abs_diff(rd_data_r.val, target_r)) begin
          res_nxt = lo_m1[IW-1:0];
        end else begin
          res_nxt = lo_r[IW-1:0];
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    target_r    <= target_nxt;
    left_miss_r <= left_miss_nxt;
    left_dist_r <= left_dist_nxt;
    res_r       <= res_nxt;
    out_index_r <= out_index_nxt;
  end

endmodule

// ===== rtl/nvbs_checker.sv =====
// port-level checker for the nearest value search block, bound to the top level
// depends on nvbs_pkg and nearest_value_binary_search_defines.svh
`include "nearest_value_binary_search_defines.svh"

module nvbs_checker
  import nvbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          in_op,
  input logic          out_valid,
  input logic          out_stall,
  input logic [IW-1:0] out_nearest_index
);

  // a stalled result word holds
  `NVBS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_nearest_index), "result word changed while stalled")

  // a query keeps the block busy on the next cycle
  `NVBS_ASSERT(a_query_busy, in_valid && !in_stall && (in_op == OP_QUERY) |=> in_stall, "block took a word while a query was in work")

  // a load leaves the block free on the following cycle
  `NVBS_ASSERT(a_load_one_cycle, in_valid && !in_stall && (in_op == OP_LOAD) |=> !in_stall, "block busy after a load")

  // a result only appears at the end of a query
  `NVBS_ASSERT(a_result_from_query, $rose(out_valid) |-> $past(in_stall), "result word without a query in work")

  // reset empties the output register
  `NVBS_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result word valid after reset")

endmodule

bind nearest_value_binary_search nvbs_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_nvbs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_op            (in_op),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_nearest_index(out_nearest_index)
);
